>>> rtl/core/trqs_pkg.sv
// Shared types, constants and helpers for the sorted timestamp range store.
package trqs_pkg;

    localparam int TIME_W       = 40;
    localparam int ID_W         = 16;
    localparam int GRAN_W       = 3;
    localparam int STAT_W       = 2;
    localparam int CAPACITY_DEF = 64;

    // Operation codes
    localparam logic FUNC_PUT      = 1'b0;
    localparam logic FUNC_RETRIEVE = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_STORED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_MATCH  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE   = 2'd3;

    // Granularity codes
    localparam logic [GRAN_W-1:0] GRAN_YEAR   = 3'd0;
    localparam logic [GRAN_W-1:0] GRAN_MONTH  = 3'd1;
    localparam logic [GRAN_W-1:0] GRAN_DAY    = 3'd2;
    localparam logic [GRAN_W-1:0] GRAN_HOUR   = 3'd3;
    localparam logic [GRAN_W-1:0] GRAN_MINUTE = 3'd4;

    typedef struct packed {
        logic              func;
        logic [ID_W-1:0]   entry_id;
        logic [TIME_W-1:0] time_a;
        logic [TIME_W-1:0] time_b;
        logic [GRAN_W-1:0] granularity;
    } trqs_in_t;

    typedef struct packed {
        logic [ID_W-1:0]   result_id;
        logic [STAT_W-1:0] status;
        logic              last;
    } trqs_out_t;

    // One stored record, handed between neighboring cells
    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [ID_W-1:0]   id;
    } trqs_rec_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic      ins;
        logic      rot;
        trqs_rec_t new_rec;
    } trqs_ctrl_t;

    // Keep mask: clear the timestamp bits finer than the granularity
    function automatic logic [TIME_W-1:0] gran_mask(input logic [GRAN_W-1:0] g);
        logic [TIME_W-1:0] ones;
        ones = '1;
        case (g)
            GRAN_YEAR:   gran_mask = ones << 26;
            GRAN_MONTH:  gran_mask = ones << 22;
            GRAN_DAY:    gran_mask = ones << 17;
            GRAN_HOUR:   gran_mask = ones << 12;
            GRAN_MINUTE: gran_mask = ones << 6;
            default:     gran_mask = ones;
        endcase
    endfunction

endpackage

>>> rtl/core/trqs_cell.sv
// One slot of the sorted record chain: compare, shift on insert, rotate on scan.
module trqs_cell
    import trqs_pkg::*;
(
    input  logic       clk,
    input  trqs_ctrl_t ctrl,
    input  logic       occ,
    input  logic       prev_gt,
    input  trqs_rec_t  prev_rec,
    input  trqs_rec_t  right_rec,
    output logic       gt,
    output trqs_rec_t  rec
);

    trqs_rec_t rec_reg;
    trqs_rec_t rec_next;

    assign rec = rec_reg;

    // Flag an occupied slot whose stamp sorts after the incoming record
    assign gt = occ && (rec_reg.stamp > ctrl.new_rec.stamp);

    // Rotate left on scan; on insert take the left neighbor or the new record
    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.rot)
        begin
            rec_next = right_rec;
        end
        else if (ctrl.ins)
        begin
            if (prev_gt)
            begin
                rec_next = prev_rec;
            end
            else if (gt || !occ)
            begin
                rec_next = ctrl.new_rec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

>>> rtl/core/timestamp_range_query_sorted.sv
// Top level: row of record cells with the put / range-scan sequencer.
// Put: accepted while idle, result strobed on the next cycle; puts may go back to back.
// Retrieve: busy through a scan state (the chain rotates once past the head cell) and
// then a flush state; matches are strobed in sorted order.
// Results cannot be stalled by the receiver. Reset (rst_n low, async) empties the
// table and returns the sequencer to idle; record contents are not cleared.
module timestamp_range_query_sorted
    import trqs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  trqs_in_t  item,
    output trqs_out_t result,
    output logic      strobe
);

    localparam int KW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] { IDLE, SCAN, FLUSH } state_t;

    state_t            state_reg,  state_next;
    logic [KW-1:0]     k_reg,      k_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic [TIME_W-1:0] lo_reg,     lo_next;
    logic [TIME_W-1:0] hi_reg,     hi_next;
    logic [TIME_W-1:0] mask_reg,   mask_next;
    logic              pend_reg,   pend_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    trqs_out_t         result_reg, result_next;
    logic              strobe_reg, strobe_next;

    trqs_ctrl_t        ctrl;
    trqs_rec_t         recs [CAPACITY];
    logic              gts  [CAPACITY];
    logic              full;
    logic              accept;
    logic [TIME_W-1:0] head_kept;
    logic              hit;
    logic [TIME_W-1:0] m_in;

    assign busy   = (state_reg != IDLE);
    assign result = result_reg;
    assign strobe = strobe_reg;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(CAPACITY));
    assign m_in   = gran_mask(item.granularity);

    // Broadcast control to the chain
    assign ctrl.ins           = accept && (item.func == FUNC_PUT) && !full;
    assign ctrl.rot           = (state_reg == SCAN);
    assign ctrl.new_rec.stamp = item.time_a;
    assign ctrl.new_rec.id    = item.entry_id;

    // Build the row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic      occ_i;
        logic      prev_gt_i;
        trqs_rec_t prev_rec_i;

        assign occ_i = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign prev_gt_i  = 1'b0;
            assign prev_rec_i = ctrl.new_rec;
        end
        else
        begin : g_rest
            assign prev_gt_i  = gts[i-1];
            assign prev_rec_i = recs[i-1];
        end

        trqs_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occ       (occ_i),
            .prev_gt   (prev_gt_i),
            .prev_rec  (prev_rec_i),
            .right_rec (recs[(i + 1) % CAPACITY]),
            .gt        (gts[i]),
            .rec       (recs[i])
        );
    end

    // Test the head cell against the kept range
    assign head_kept = recs[0].stamp & mask_reg;
    assign hit = (CW'(k_reg) < count_reg) && (head_kept >= lo_reg) && (head_kept <= hi_reg);

    // Sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mask_next    = mask_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        result_next  = result_reg;
        strobe_next  = 1'b0;

        case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    if (item.func == FUNC_PUT)
                    begin
                        strobe_next           = 1'b1;
                        result_next.result_id = '0;
                        result_next.last      = 1'b1;
                        if (full)
                        begin
                            result_next.status = ST_FULL;
                        end
                        else
                        begin
                            result_next.status = ST_STORED;
                            count_next         = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        lo_next    = item.time_a & m_in;
                        hi_next    = item.time_b & m_in;
                        mask_next  = m_in;
                        k_next     = '0;
                        pend_next  = 1'b0;
                        state_next = SCAN;
                    end
                end
            end
            SCAN:
            begin
                // Release the held match once a newer one shows up
                if (hit)
                begin
                    if (pend_reg)
                    begin
                        strobe_next           = 1'b1;
                        result_next.result_id = pend_id_reg;
                        result_next.status    = ST_MATCH;
                        result_next.last      = 1'b0;
                    end
                    pend_next    = 1'b1;
                    pend_id_next = recs[0].id;
                end
                k_next = k_reg + KW'(1);
                if (k_reg == KW'(CAPACITY - 1))
                begin
                    state_next = FLUSH;
                end
            end
            FLUSH:
            begin
                strobe_next      = 1'b1;
                result_next.last = 1'b1;
                if (pend_reg)
                begin
                    result_next.result_id = pend_id_reg;
                    result_next.status    = ST_MATCH;
                end
                else
                begin
                    result_next.result_id = '0;
                    result_next.status    = ST_NONE;
                end
                state_next = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // Hold control state and the registered strobe output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
            k_reg      <= k_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mask_reg    <= mask_next;
        pend_id_reg <= pend_id_next;
        result_reg  <= result_next;
    end

endmodule

>>> rtl/core/trqs_checker.sv
// Port-level checker for the sorted timestamp range store, bound to the top level.
module trqs_checker
    import trqs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input trqs_in_t  item,
    input trqs_out_t result,
    input logic      strobe
);

    // A put gets its single result on the next cycle
    a_put_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.func == FUNC_PUT) |=> strobe)
        else $error("put result missing");

    // Put and no-match results are single, final and carry no id
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.status == ST_STORED || result.status == ST_FULL ||
                   result.status == ST_NONE) |-> result.last && (result.result_id == '0))
        else $error("single-beat result malformed");

    // Non-final matches only appear while a retrieve is still running
    a_mid_match: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy && (result.status == ST_MATCH))
        else $error("non-final beat outside a retrieve");

    // A retrieve ends with its final beat
    a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && result.last)
        else $error("retrieve ended without a final beat");

endmodule

bind timestamp_range_query_sorted trqs_checker u_trqs_checker (.*);

>>> test/trqs_table_checker.sv
// Checker for the sorted timestamp range store: predicts each result and compares.
module trqs_table_checker
    import trqs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  trqs_in_t  item,
    input  trqs_out_t result,
    input  logic      strobe,
    output int        errors,
    output int        outstanding,
    output int        puts_taken,
    output int        scans_taken,
    output int        full_drops,
    output int        match_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the sorted records, oldest tie first
    logic [TIME_W-1:0] rec_time[$];
    logic [ID_W-1:0]   rec_id[$];
    // Results still owed by the block, in strobe order
    trqs_out_t         due_results[$];

    // Count a failure, print only the first few
    function automatic void note_failure(string what, trqs_out_t want, trqs_out_t got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s: expected id %h status %0d last %0d, got id %h status %0d last %0d",
                     $realtime, what, want.result_id, want.status, want.last,
                     got.result_id, got.status, got.last);
    endfunction

    // Append one owed result at the tail of the queue
    function automatic void owe_result(trqs_out_t r);
        due_results.insert(due_results.size(), r);
    endfunction

    // Insert after every record whose stamp is not later than the new one
    function automatic void store_record(logic [ID_W-1:0] id, logic [TIME_W-1:0] stamp);
        int slot;
        slot = rec_time.size();
        while (slot > 0 && rec_time[slot-1] > stamp)
            slot--;
        rec_time.insert(slot, stamp);
        rec_id.insert(slot, id);
    endfunction

    // Work out every result one accepted beat causes
    function automatic void predict_beat(trqs_in_t beat);
        trqs_out_t         r;
        int                shift;
        int                hits;
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        logic [TIME_W-1:0] t;
        r = '0;
        if (beat.func == FUNC_PUT)
        begin
            puts_taken++;
            r.last = 1'b1;
            if (rec_time.size() >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                store_record(beat.entry_id, beat.time_a);
                r.status = ST_STORED;
            end
            owe_result(r);
        end
        else
        begin
            scans_taken++;
            case (beat.granularity)
                GRAN_YEAR:   shift = 26;
                GRAN_MONTH:  shift = 22;
                GRAN_DAY:    shift = 17;
                GRAN_HOUR:   shift = 12;
                GRAN_MINUTE: shift = 6;
                default:     shift = 0;
            endcase
            lo = beat.time_a >> shift;
            hi = beat.time_b >> shift;
            hits = 0;
            foreach (rec_time[i])
            begin
                t = rec_time[i] >> shift;
                if (t >= lo && t <= hi)
                begin
                    r.result_id = rec_id[i];
                    r.status    = ST_MATCH;
                    r.last      = 1'b0;
                    owe_result(r);
                    hits++;
                end
            end
            if (hits == 0)
            begin
                r.result_id = '0;
                r.status    = ST_NONE;
                r.last      = 1'b1;
                owe_result(r);
            end
            else
            begin
                due_results[due_results.size()-1].last = 1'b1;
            end
        end
    endfunction

    // Compare a strobed result with the oldest one owed
    function automatic void check_result(trqs_out_t got);
        trqs_out_t want;
        if (due_results.size() == 0)
        begin
            note_failure("result with nothing pending", '0, got);
            return;
        end
        want = due_results.pop_front();
        if (got.status == ST_FULL)
            full_drops++;
        if (got.status == ST_MATCH)
            match_hits++;
        if (got.result_id !== want.result_id || got.status !== want.status ||
            got.last !== want.last)
            note_failure("result mismatch", want, got);
    endfunction

    // Watch both channels; results of earlier beats come before new predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_time.delete();
            rec_id.delete();
            due_results.delete();
            errors      = 0;
            puts_taken  = 0;
            scans_taken = 0;
            full_drops  = 0;
            match_hits  = 0;
            outstanding = 0;
        end
        else
        begin
            if (strobe)
                check_result(result);
            if (start && !busy)
                predict_beat(item);
            outstanding = due_results.size();
        end
    end

endmodule

>>> test/timestamp_range_query_sorted_test.sv
// Stimulus and verdict for the sorted timestamp range store.
module timestamp_range_query_sorted_test;
    timeunit 1ns;
    timeprecision 1ps;
    import trqs_pkg::*;

    localparam logic [GRAN_W-1:0] GRAN_SECOND = 3'd5;
    localparam int RANDOM_BEATS = 84;
    localparam int RUN_LIMIT    = 200000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    logic      strobe;
    trqs_in_t  item = '0;
    trqs_out_t result;

    int errors;
    int outstanding;
    int puts_taken;
    int scans_taken;
    int full_drops;
    int match_hits;
    int cycle_count = 0;
    bit steady_run = 1'b0;

    // Stamps already put, to aim range bounds at stored records
    logic [TIME_W-1:0] put_stamps[$];

    timestamp_range_query_sorted #(.CAPACITY(CAPACITY_DEF)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .result (result),
        .strobe (strobe)
    );

    trqs_table_checker #(.CAPACITY(CAPACITY_DEF)) u_table_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result      (result),
        .strobe      (strobe),
        .errors      (errors),
        .outstanding (outstanding),
        .puts_taken  (puts_taken),
        .scans_taken (scans_taken),
        .full_drops  (full_drops),
        .match_hits  (match_hits)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("[timestamp_range_query_sorted] ERROR");
            $finish;
        end
    end

    function automatic logic [TIME_W-1:0] pack_stamp(int y, int mo, int d, int h, int mi, int s);
        return (TIME_W'(y) << 26) | (TIME_W'(mo) << 22) | (TIME_W'(d) << 17) |
               (TIME_W'(h) << 12) | (TIME_W'(mi) << 6) | TIME_W'(s);
    endfunction

    function automatic logic [TIME_W-1:0] raw_stamp();
        return TIME_W'({$urandom, $urandom});
    endfunction

    function automatic logic [TIME_W-1:0] calendar_stamp();
        return pack_stamp($urandom_range(2010, 2017), $urandom_range(1, 12),
                          $urandom_range(1, 31), $urandom_range(0, 23),
                          $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    function automatic logic [TIME_W-1:0] known_stamp();
        if (put_stamps.size() == 0)
            return calendar_stamp();
        return put_stamps[$urandom_range(0, put_stamps.size() - 1)];
    endfunction

    // Build a put beat; fill the fields it ignores with noise
    function automatic trqs_in_t put_beat(logic [ID_W-1:0] id, logic [TIME_W-1:0] stamp);
        trqs_in_t b;
        b.func        = FUNC_PUT;
        b.entry_id    = id;
        b.time_a      = stamp;
        b.time_b      = raw_stamp();
        b.granularity = GRAN_W'($urandom_range(0, 7));
        return b;
    endfunction

    function automatic trqs_in_t scan_beat(logic [TIME_W-1:0] lo, logic [TIME_W-1:0] hi,
                                           logic [GRAN_W-1:0] g);
        trqs_in_t b;
        b.func        = FUNC_RETRIEVE;
        b.entry_id    = ID_W'($urandom);
        b.time_a      = lo;
        b.time_b      = hi;
        b.granularity = g;
        return b;
    endfunction

    // Hold a beat on the port until the block takes it
    task automatic send_beat(input trqs_in_t beat);
        start <= 1'b1;
        item  <= beat;
        if (beat.func == FUNC_PUT)
            put_stamps = {put_stamps, beat.time_a};
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    // Idle the sender: mostly short gaps, a few long, none during a steady run
    task automatic pause_sender();
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        if (steady_run || roll < 45)
            n = 0;
        else if (roll < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0] year_end;
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        logic [TIME_W-1:0] swap;
        trqs_in_t          beat;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty scan, extreme fields, ties, off-calendar stamp
        year_end = pack_stamp(2017, 12, 31, 23, 59, 59);
        send_beat(scan_beat('0, '1, GRAN_YEAR));
        send_beat(put_beat(16'hFFFF, '1));
        send_beat(put_beat(16'h0000, '0));
        send_beat(put_beat(16'h0001, pack_stamp(2000, 0, 0, 0, 0, 0)));
        send_beat(put_beat(16'h0002, year_end));
        send_beat(put_beat(16'h0003, year_end));
        send_beat(put_beat(16'h0004, year_end));
        send_beat(put_beat(16'hA5A5, pack_stamp(2010, 15, 31, 31, 63, 63)));

        // Sweep every granularity code, including the two past seconds
        lo = pack_stamp(2017, 1, 1, 0, 0, 0);
        hi = pack_stamp(2017, 12, 31, 23, 59, 58);
        for (int g = 0; g < 8; g++)
            send_beat(scan_beat(lo, hi, GRAN_W'(g)));

        // Start after end, whole range, single exact stamp
        send_beat(scan_beat('1, '0, GRAN_YEAR));
        send_beat(scan_beat('0, '1, GRAN_SECOND));
        send_beat(scan_beat(year_end, year_end, GRAN_SECOND));

        // Random: mostly puts so the table fills, scans aimed at stored stamps
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if ($urandom_range(0, 11) == 0)
                steady_run = !steady_run;
            pause_sender();
            if ($urandom_range(0, 99) < 72)
            begin
                case ($urandom_range(0, 6))
                    0:       lo = raw_stamp();
                    1:       lo = known_stamp();
                    default: lo = calendar_stamp();
                endcase
                beat = put_beat(ID_W'($urandom), lo);
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    lo = known_stamp();
                    hi = known_stamp();
                end
                else
                begin
                    lo = $urandom_range(0, 1) ? raw_stamp() : calendar_stamp();
                    hi = $urandom_range(0, 1) ? raw_stamp() : calendar_stamp();
                end
                // Order the bounds most of the time; leave some reversed
                if (lo > hi && $urandom_range(0, 99) < 85)
                begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
                beat = scan_beat(lo, hi, GRAN_W'($urandom_range(0, 7)));
            end
            send_beat(beat);
        end
        start <= 1'b0;

        // Drain: wait out every owed result, then let the clock run on before the verdict
        while (outstanding != 0)
            @(posedge clk);
        repeat (CAPACITY_DEF + 8) @(posedge clk);

        $display("Covered %0d puts (%0d refused on a full table) and %0d range scans",
                 puts_taken, full_drops, scans_taken);
        $display("Scans returned %0d matching ids; %0d failures", match_hits, errors);
        if (errors == 0 && outstanding == 0)
            $display("[timestamp_range_query_sorted] OK");
        else
            $display("[timestamp_range_query_sorted] ERROR");
        $finish;
    end

endmodule
